// ===== hdl/dst_rule_offset_eval_top_defines.svh =====
// ----------------------------------------------------------------------------
// dst_rule_offset_eval_top_defines.svh
// Assertion macros shared by the daylight saving offset evaluator.
// ----------------------------------------------------------------------------
`ifndef DST_RULE_OFFSET_EVAL_TOP_DEFINES_SVH
`define DST_RULE_OFFSET_EVAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DRE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dre assertion failed");
`define DRE_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dre assertion failed");
`else
`define DRE_ASSERT(lbl, prop)
`define DRE_ASSERT_NR(lbl, prop)
`endif
`endif

// ===== hdl/dre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dre_pkg
// Constants and calendar helpers for the daylight saving offset evaluator.
// ----------------------------------------------------------------------------
package dre_pkg;

    typedef logic [3:0] t_stage_en;

    localparam logic [2:0] CFG_DST_ENABLE = 3'd0;
    localparam logic [2:0] CFG_STD_OFFSET = 3'd1;
    localparam logic [2:0] CFG_DST_OFFSET = 3'd2;
    localparam logic [2:0] CFG_START_DATE = 3'd3;
    localparam logic [2:0] CFG_START_TIME = 3'd4;
    localparam logic [2:0] CFG_END_DATE   = 3'd5;
    localparam logic [2:0] CFG_END_TIME   = 3'd6;

    // t / 86400 == (t >> 7) / 675, reciprocal exact for 25-bit operands
    localparam logic [25:0] RECIP_675  = 26'd50903317;
    // (4d+3) / 1461, exact for 18-bit operands
    localparam logic [18:0] RECIP_1461 = 19'd367469;
    // x / 7, exact for 17-bit operands
    localparam logic [17:0] RECIP_7    = 18'd149797;
    // day number of 2100-03-01; 2100 is not a leap year
    localparam logic [15:0] DAY_2100_MAR = 16'd47541;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        unique case (m)
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/dre_trans.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dre_trans
// Four-stage pipeline turning a year start and a date rule into a UTC epoch.
// ----------------------------------------------------------------------------
module dre_trans (
    input  logic              i_clk,
    input  dre_pkg::t_stage_en i_en,
    input  logic [15:0]       i_ys,     // day number of Jan 1 of the year
    input  logic              i_leap,
    input  logic [9:0]        i_date,   // [3:0] month, [6:4] week, [9:7] weekday
    input  logic [31:0]       i_bias,   // time of day minus offset, seconds
    output logic [31:0]       o_utc
);

    logic [3:0]  w_m;
    logic [2:0]  w_wk;
    logic [2:0]  w_wd;

    logic [15:0] r4_first;
    logic        r4_leap;
    logic [15:0] r5_first;
    logic [2:0]  r5_fdow;
    logic        r5_leap;
    logic [15:0] r6_dtr;
    logic [31:0] r7_utc;

    logic [15:0] n4_first;
    logic [16:0] w5_x;
    logic [34:0] w5_p;
    logic [16:0] w5_q;
    logic [16:0] w5_rem;
    logic [3:0]  w6_diff;
    logic [2:0]  w6_mod;
    logic [5:0]  w6_day;
    logic [5:0]  w6_dim;
    logic [32:0] w7_p;

    // clamp the rule fields; config must stay stable while items are in flight (the user's duty, not enforced here)
    always_comb begin
        w_m  = i_date[3:0];
        if (w_m == 4'd0) w_m = 4'd1;
        if (w_m > 4'd12) w_m = 4'd12;
        w_wk = i_date[6:4];
        if (w_wk == 3'd0) w_wk = 3'd1;
        if (w_wk > 3'd5)  w_wk = 3'd5;
        w_wd = (i_date[9:7] == 3'd7) ? 3'd0 : i_date[9:7];
    end

    assign n4_first = i_ys + 16'(dre_pkg::month_start(w_m))
                    + 16'((i_leap && w_m > 4'd2) ? 1 : 0);

    // weekday of the first of the month: (first + 4) mod 7
    assign w5_x   = 17'(r4_first) + 17'd4;
    assign w5_p   = 35'(w5_x) * 35'(dre_pkg::RECIP_7);
    assign w5_q   = 17'(w5_p[34:20]);
    assign w5_rem = w5_x - 17'(w5_q * 17'd7);

    always_comb begin
        w6_diff = 4'd7 + 4'(w_wd) - 4'(r5_fdow);
        w6_mod  = (w6_diff >= 4'd7) ? 3'(w6_diff - 4'd7) : w6_diff[2:0];
        w6_dim  = 6'(dre_pkg::month_len(w_m, r5_leap));
        w6_day  = 6'd1 + 6'(w6_mod) + 6'(6'(w_wk - 3'd1) * 6'd7);
        if (w6_day > w6_dim) w6_day = w6_day - 6'd7;
    end

    assign w7_p = 33'(r6_dtr) * 33'(dre_pkg::SECS_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_first <= n4_first;
            r4_leap  <= i_leap;
        end
        if (i_en[1]) begin
            r5_first <= r4_first;
            r5_fdow  <= w5_rem[2:0];
            r5_leap  <= r4_leap;
        end
        if (i_en[2]) begin
            r6_dtr <= r5_first + 16'(w6_day) - 16'd1;
        end
        if (i_en[3]) begin
            r7_utc <= w7_p[31:0] + i_bias;
        end
    end

    assign o_utc = r7_utc;

endmodule

// ===== hdl/dst_rule_offset_eval_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_rule_offset_eval_top
// Local offset and daylight flag for a UTC epoch under an "M" DST rule.
// ----------------------------------------------------------------------------
// One epoch is taken per clock unless a stalled output has filled every stage;
// each result moves through the stages day split, year estimate, year start,
// month start, weekday, transition day, transition epoch, window compare.
// Each stage holds on its own when the next one is full, so a stalled output
// does not stop items from filling the empty stages behind it. Configuration
// writes are accepted every cycle and must only be made while the pipeline
// is empty.
`include "dst_rule_offset_eval_top_defines.svh"

module dst_rule_offset_eval_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] utc_time
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [11:0] offset_min, [15:12] zero
    output logic        o_m_axis_tuser,   // [0] dst_active
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data
);

    logic        r_dst_enable;
    logic [11:0] r_std_offset;
    logic [11:0] r_dst_offset;
    logic [9:0]  r_start_date;
    logic [17:0] r_start_time;
    logic [9:0]  r_end_date;
    logic [17:0] r_end_time;

    logic [8:1]  r_v;
    logic [9:1]  w_en;

    logic [31:0] r1_t, r2_t, r3_t, r4_t, r5_t, r6_t, r7_t;
    logic [50:0] r1_p;
    logic [36:0] r2_p;
    logic [15:0] r3_ys;
    logic        r3_leap;
    logic [11:0] r_off;
    logic        r_act;

    logic [15:0] w2_days;
    logic [15:0] w2_dp;
    logic [17:0] w2_x;
    logic [7:0]  w3_yoff;
    logic [7:0]  w3_yi;
    logic [15:0] n3_ys;
    logic        n3_leap;
    logic [31:0] w_bias_s;
    logic [31:0] w_bias_e;
    logic [31:0] w_s;
    logic [31:0] w_e;
    logic        w_act;
    dre_pkg::t_stage_en w_sub_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_enable <= 1'b0;
            r_std_offset <= 12'd0;
            r_dst_offset <= 12'd60;
            r_start_date <= 10'd35;
            r_start_time <= 18'd7200;
            r_end_date   <= 10'd27;
            r_end_time   <= 18'd7200;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dre_pkg::CFG_DST_ENABLE: r_dst_enable <= i_cfg_data[0];
                dre_pkg::CFG_STD_OFFSET: r_std_offset <= i_cfg_data[11:0];
                dre_pkg::CFG_DST_OFFSET: r_dst_offset <= i_cfg_data[11:0];
                dre_pkg::CFG_START_DATE: r_start_date <= i_cfg_data[9:0];
                dre_pkg::CFG_START_TIME: r_start_time <= i_cfg_data;
                dre_pkg::CFG_END_DATE:   r_end_date   <= i_cfg_data[9:0];
                dre_pkg::CFG_END_TIME:   r_end_time   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage advance: a stage loads when it is empty or its content moves on
    always_comb begin
        w_en[9] = i_m_axis_tready;
        for (int k = 8; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= 8; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 2: day number, shifted to a Julian 4-year cycle from 1969
    assign w2_days = r1_p[50:35];
    assign w2_dp   = w2_days + 16'd365 + 16'((w2_days >= dre_pkg::DAY_2100_MAR) ? 1 : 0);
    assign w2_x    = {w2_dp, 2'b11};

    // stage 3: year index, leap flag and day number of Jan 1
    assign w3_yoff = r2_p[36:29];
    assign w3_yi   = w3_yoff - 8'd1;
    assign n3_leap = (w3_yoff[1:0] == 2'b11) && (w3_yoff != 8'd131);
    assign n3_ys   = 16'(16'(w3_yi) * 16'd365) + 16'(w3_yoff[7:2])
                   - 16'((w3_yoff > 8'd131) ? 1 : 0);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_t <= i_s_axis_tdata;
            r1_p <= 51'(i_s_axis_tdata[31:7]) * 51'(dre_pkg::RECIP_675);
        end
        if (w_en[2]) begin
            r2_t <= r1_t;
            r2_p <= 37'(w2_x) * 37'(dre_pkg::RECIP_1461);
        end
        if (w_en[3]) begin
            r3_t    <= r2_t;
            r3_ys   <= n3_ys;
            r3_leap <= n3_leap;
        end
        if (w_en[4]) r4_t <= r3_t;
        if (w_en[5]) r5_t <= r4_t;
        if (w_en[6]) r6_t <= r5_t;
        if (w_en[7]) r7_t <= r6_t;
    end

    assign w_bias_s = 32'(r_start_time)
                    - 32'(32'(signed'(r_std_offset)) * 32'sd60);
    assign w_bias_e = 32'(r_end_time)
                    - 32'(32'(signed'(r_dst_offset)) * 32'sd60);
    assign w_sub_en = w_en[7:4];

    dre_trans u_start (
        .i_clk  (i_clk),
        .i_en   (w_sub_en),
        .i_ys   (r3_ys),
        .i_leap (r3_leap),
        .i_date (r_start_date),
        .i_bias (w_bias_s),
        .o_utc  (w_s)
    );

    dre_trans u_end (
        .i_clk  (i_clk),
        .i_en   (w_sub_en),
        .i_ys   (r3_ys),
        .i_leap (r3_leap),
        .i_date (r_end_date),
        .i_bias (w_bias_e),
        .o_utc  (w_e)
    );

    // the window wraps past the new year when start lies after end
    always_comb begin
        if (w_s <= w_e) w_act = (r7_t >= w_s) && (r7_t < w_e);
        else            w_act = (r7_t >= w_s) || (r7_t < w_e);
        w_act = w_act && r_dst_enable;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_act <= w_act;
            r_off <= w_act ? r_dst_offset : r_std_offset;
        end
    end

    assign o_m_axis_tvalid = r_v[8];
    assign o_m_axis_tdata  = {4'd0, r_off};
    assign o_m_axis_tuser  = r_act;

    `DRE_ASSERT(a_flag_needs_enable, o_m_axis_tvalid && o_m_axis_tuser |-> r_dst_enable)
    `DRE_ASSERT(a_std_when_off, o_m_axis_tvalid && !o_m_axis_tuser |-> r_off == r_std_offset)
    `DRE_ASSERT(a_dst_when_on, o_m_axis_tvalid && o_m_axis_tuser |-> r_off == r_dst_offset)
    `DRE_ASSERT(a_stall_only_full, !o_s_axis_tready |-> (&r_v) && !i_m_axis_tready)
    `DRE_ASSERT_NR(a_reset_empty, !i_rst_n |=> r_v == '0)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dst_rule_offset_eval_top: epochs are streamed in,
// each result is checked against an in-bench calendar/DST rule predictor.
// Covers disabled rule, transition edges, malformed rule fields, southern
// wrap, random rules under three idle mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [11:0] offset_min;
        logic        dst_active;
    } t_local_offset;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] utc_time
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;        // [11:0] offset_min, [15:12] zero
    logic        o_m_axis_tuser;        // [0] dst_active
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [17:0] i_cfg_data = '0;

    dst_rule_offset_eval_top u_dut (.*);

    always #6 i_clk = ~i_clk;

    // rule registers as the block should hold them
    logic        rule_enable;
    logic [11:0] rule_std_off;
    logic [11:0] rule_dst_off;
    logic [9:0]  rule_start_date;
    logic [17:0] rule_start_tod;
    logic [9:0]  rule_end_date;
    logic [17:0] rule_end_tod;

    t_local_offset expected_offsets[$];
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_cycles = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_errors = 0;
    int quiet_cycles = 0;

    // ---------------- calendar predictor ----------------
    function automatic bit [31:0] day_index_of(bit [31:0] y, bit [31:0] m, bit [31:0] d);
        bit [31:0] era, yoe, doy, doe;
        if (m <= 2) y = y - 1;
        era = y / 400;
        yoe = y - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic bit [31:0] month_length_of(bit [31:0] y, bit [31:0] m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit [31:0] transition_epoch(bit [31:0] year, logic [9:0] date,
                                                   logic [17:0] tod,
                                                   logic signed [11:0] off);
        bit [31:0] m, w, wd, first, fdow, day, dim, adj;
        m = date[3:0];
        w = date[6:4];
        wd = date[9:7] % 7;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        if (w < 1) w = 1;
        if (w > 5) w = 5;
        first = day_index_of(year, m, 1);
        fdow = (first + 4) % 7;
        day = 1 + (7 + wd - fdow) % 7 + (w - 1) * 7;
        dim = month_length_of(year, m);
        while (day > dim) day = day - 7;
        adj = 32'(int'(off) * 60);
        return day_index_of(year, m, day) * 86400 + 32'(tod) - adj;
    endfunction

    function automatic bit [31:0] civil_year(bit [31:0] t);
        bit [31:0] z, era, doe, yoe, doy, mp;
        z = t / 86400 + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        return yoe + era * 400 + (mp >= 10 ? 1 : 0);
    endfunction

    function automatic t_local_offset local_offset_of(bit [31:0] t);
        t_local_offset r;
        bit [31:0] y, s, e;
        bit act;
        if (!rule_enable) begin
            r.offset_min = rule_std_off;
            r.dst_active = 1'b0;
            return r;
        end
        y = civil_year(t);
        s = transition_epoch(y, rule_start_date, rule_start_tod, rule_std_off);
        e = transition_epoch(y, rule_end_date, rule_end_tod, rule_dst_off);
        if (s <= e) act = (t >= s) && (t < e);
        else        act = (t >= s) || (t < e);
        r.offset_min = act ? rule_dst_off : rule_std_off;
        r.dst_active = act;
        return r;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(logic [2:0] idx, logic [17:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dre_pkg::CFG_DST_ENABLE: rule_enable     = val[0];
            dre_pkg::CFG_STD_OFFSET: rule_std_off    = val[11:0];
            dre_pkg::CFG_DST_OFFSET: rule_dst_off    = val[11:0];
            dre_pkg::CFG_START_DATE: rule_start_date = val[9:0];
            dre_pkg::CFG_START_TIME: rule_start_tod  = val;
            dre_pkg::CFG_END_DATE:   rule_end_date   = val[9:0];
            dre_pkg::CFG_END_TIME:   rule_end_tod    = val;
            default: ;
        endcase
        n_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_rule(logic en, int std_off, int dst_off, logic [9:0] sd,
                             logic [17:0] st, logic [9:0] ed, logic [17:0] et);
        write_reg(dre_pkg::CFG_DST_ENABLE, 18'(en));
        write_reg(dre_pkg::CFG_STD_OFFSET, 18'(std_off) & 18'hFFF);
        write_reg(dre_pkg::CFG_DST_OFFSET, 18'(dst_off) & 18'hFFF);
        write_reg(dre_pkg::CFG_START_DATE, 18'(sd));
        write_reg(dre_pkg::CFG_START_TIME, st);
        write_reg(dre_pkg::CFG_END_DATE, 18'(ed));
        write_reg(dre_pkg::CFG_END_TIME, et);
    endtask

    task automatic send_epoch(bit [31:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= t;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_offsets.push_back(local_offset_of(t));
        n_requests++;
    endtask

    // probe just before and at both rule transitions of the given year
    task automatic send_edges(bit [31:0] year);
        bit [31:0] s, e;
        s = transition_epoch(year, rule_start_date, rule_start_tod, rule_std_off);
        e = transition_epoch(year, rule_end_date, rule_end_tod, rule_dst_off);
        send_epoch(s - 1);
        send_epoch(s);
        send_epoch(e - 1);
        send_epoch(e);
    endtask

    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_offsets.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);   // pipeline is 8 deep
    endtask

    // ---------------- sink and checker ----------------
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles--;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("ERROR @%0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_local_offset exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (expected_offsets.size() == 0) begin
                report_mismatch("unexpected result, offset", 0, o_m_axis_tdata[11:0]);
            end else begin
                exp_r = expected_offsets.pop_front();
                if (o_m_axis_tdata[11:0] !== exp_r.offset_min)
                    report_mismatch("offset_min", exp_r.offset_min, o_m_axis_tdata[11:0]);
                if (o_m_axis_tuser !== exp_r.dst_active)
                    report_mismatch("dst_active", exp_r.dst_active, o_m_axis_tuser);
            end
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("timeout: no handshake for %0d cycles", quiet_cycles);
                $display("dst_rule_offset_eval_top: mismatch");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_rule_disabled;
        send_epoch(32'h0);
        send_epoch(32'hFFFF_FFFF);
        send_epoch(32'hAAAA_AAAA);
        drain();
        write_reg(dre_pkg::CFG_STD_OFFSET, 18'(-1500) & 18'hFFF);
        send_epoch(32'h5555_5555);
        drain();
    endtask

    task automatic test_transition_edges;
        // US style: second Sunday in March to first Sunday in November
        load_rule(1'b1, -300, -240, 10'd35, 18'd7200, 10'd27, 18'd7200);
        send_edges(2024);
        send_epoch(32'h0);
        send_epoch(32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_odd_rules;
        // month 0, week 0, weekday 7 / month 15, week 7, weekday 6, huge start time
        load_rule(1'b1, 1500, -1500, 10'd896, 18'd262143, 10'd895, 18'd0);
        send_edges(2000);
        drain();
        // start equals end: window is empty
        load_rule(1'b1, 60, 60, 10'd35, 18'd3600, 10'd35, 18'd3600);
        send_edges(2010);
        drain();
        // southern hemisphere: window wraps past new year
        load_rule(1'b1, 600, 660, 10'd26, 18'd7200, 10'd20, 18'd10800);
        send_edges(2100);
        send_epoch(32'd4102444800);   // 2100-01-01
        drain();
    endtask

    task automatic test_random_rules(int n_rules, int per_rule);
        bit [31:0] year, t;
        for (int r = 0; r < n_rules; r++) begin
            if (r == 0)
                load_rule(1'b1, -1500, 1500, 10'($urandom), 18'($urandom_range(86399)),
                          10'($urandom), 18'($urandom_range(86399)));
            else
                load_rule($urandom_range(9) != 0, $urandom_range(3000) - 1500,
                          $urandom_range(3000) - 1500, 10'($urandom),
                          ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(86399)),
                          10'($urandom),
                          ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(86399)));
            for (int i = 0; i < per_rule; i++) begin
                if ($urandom_range(9) < 6) begin
                    year = $urandom_range(2105, 1970);
                    t = ($urandom_range(1) != 0)
                        ? transition_epoch(year, rule_start_date, rule_start_tod, rule_std_off)
                        : transition_epoch(year, rule_end_date, rule_end_tod, rule_dst_off);
                    send_epoch(t + $urandom_range(7200) - 3600);
                end else begin
                    send_epoch($urandom);
                end
            end
            drain();
        end
    endtask

    task automatic test_output_stall;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_rule(1'b1, 60, 120, 10'd37, 18'd3600, 10'd42, 18'd3600);
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) send_epoch($urandom);
        drain();
    endtask

    initial begin
        rule_enable = 1'b0;
        rule_std_off = 12'd0;
        rule_dst_off = 12'd60;
        rule_start_date = 10'd35;
        rule_start_tod = 18'd7200;
        rule_end_date = 10'd27;
        rule_end_tod = 18'd7200;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rule_disabled();
        test_transition_edges();
        test_odd_rules();
        src_idle_pct = 21; snk_idle_pct = 59;
        test_random_rules(6, 45);
        src_idle_pct = 59; snk_idle_pct = 21;
        test_random_rules(6, 45);
        src_idle_pct = 0; snk_idle_pct = 0;
        test_random_rules(6, 45);
        test_output_stall();

        $display("covered: %0d epochs, %0d results, %0d register writes", n_requests,
                 n_results, n_writes);
        $display("rules: disabled, edges, malformed fields, wraparound, random, stall");
        if (n_errors == 0) begin
            $display("dst_rule_offset_eval_top: match");
        end else begin
            $display("dst_rule_offset_eval_top: mismatch");
        end
        $finish;
    end
endmodule
